### rtl/core/pasc_pkg.sv
`default_nettype none

package pasc_pkg;

	// field widths fixed by the interface
	localparam int POS_W = 7;
	localparam int LEN_W = 8;

	// default sizes handed to the top level
	localparam int MAX_POINTS_DEF = 256;
	localparam int MAX_WORDS_DEF  = 128;

	// a stored point is src in the upper half, tgt in the lower half
	localparam int POINT_W = 2 * POS_W;

	// input word
	typedef struct packed {
		logic             func;
		logic             first_point;
		logic [POS_W-1:0] src_pos;
		logic [POS_W-1:0] tgt_pos;
		logic [POS_W-1:0] span_start;
		logic [POS_W-1:0] span_end;
		logic [LEN_W-1:0] tgt_length;
	} in_word_t;

	// result word
	typedef struct packed {
		logic             consistent;
		logic [LEN_W-1:0] phrase_tgt_start;
		logic [POS_W-1:0] phrase_tgt_end;
		logic [POS_W-1:0] nulls_before;
		logic [POS_W-1:0] nulls_after;
	} out_word_t;

	// input function codes
	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// microprogram step index
	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE  = 3'd0;
	localparam step_t STEP_BSCAN = 3'd1;
	localparam step_t STEP_BEND  = 3'd2;
	localparam step_t STEP_CSCAN = 3'd3;
	localparam step_t STEP_WINIT = 3'd4;
	localparam step_t STEP_PRE   = 3'd5;
	localparam step_t STEP_POST  = 3'd6;
	localparam step_t STEP_OUT   = 3'd7;

	// datapath operations
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_BSCAN,
		OP_BEND,
		OP_CSCAN,
		OP_WINIT,
		OP_PRE,
		OP_POST,
		OP_OUT
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_NO_QUERY,
		C_SCAN_BUSY,
		C_NO_TARGET,
		C_FAIL,
		C_PRE_MORE,
		C_POST_MORE,
		C_OUT_BUSY
	} cond_t;

	// control word: operation, jump condition, jump target
	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic no_query;
		logic scan_busy;
		logic no_target;
		logic fail;
		logic pre_more;
		logic post_more;
		logic out_busy;
	} seq_flags_t;

	// microprogram rom; falling through the last step wraps to idle
	function automatic ctrl_t ucode_rom(input step_t step);
		ctrl_t w;
		unique case (step)
			STEP_IDLE:  w = '{op: OP_IDLE,  cond: C_NO_QUERY,  target: STEP_IDLE};
			STEP_BSCAN: w = '{op: OP_BSCAN, cond: C_SCAN_BUSY, target: STEP_BSCAN};
			STEP_BEND:  w = '{op: OP_BEND,  cond: C_NO_TARGET, target: STEP_OUT};
			STEP_CSCAN: w = '{op: OP_CSCAN, cond: C_SCAN_BUSY, target: STEP_CSCAN};
			STEP_WINIT: w = '{op: OP_WINIT, cond: C_FAIL,      target: STEP_OUT};
			STEP_PRE:   w = '{op: OP_PRE,   cond: C_PRE_MORE,  target: STEP_PRE};
			STEP_POST:  w = '{op: OP_POST,  cond: C_POST_MORE, target: STEP_POST};
			STEP_OUT:   w = '{op: OP_OUT,   cond: C_OUT_BUSY,  target: STEP_OUT};
			default:    w = '{op: OP_IDLE,  cond: C_NEVER,     target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/core/pasc_ram.sv
`default_nettype none

module pasc_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/pasc_seq.sv
`default_nettype none

module pasc_seq
	import pasc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire seq_flags_t flags,
	output ctrl_t           ctrl
);

	step_t step_q;
	step_t step_nxt;
	logic  take_jump;

	// control word of the current step
	assign ctrl = ucode_rom(step_q);

	// jump condition select
	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:     take_jump = 1'b0;
			C_NO_QUERY:  take_jump = flags.no_query;
			C_SCAN_BUSY: take_jump = flags.scan_busy;
			C_NO_TARGET: take_jump = flags.no_target;
			C_FAIL:      take_jump = flags.fail;
			C_PRE_MORE:  take_jump = flags.pre_more;
			C_POST_MORE: take_jump = flags.post_more;
			C_OUT_BUSY:  take_jump = flags.out_busy;
			default:     take_jump = 1'b0;
		endcase
	end

	// next step: jump target or fall through
	always_comb begin
		if (take_jump) begin
			step_nxt = ctrl.target;
		end else begin
			step_nxt = step_q + step_t'(1);
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/core/phrase_alignment_span_check.sv
`default_nettype none

// channel | direction | handshake           | word
// in      | input     | in_valid / in_ready   | in_word  (in_word_t)
// out     | output    | out_valid / out_ready | out_word (out_word_t)
//
// an add word is taken only while the sequencer sits in idle.
// a query makes up to two passes over the stored points in the point ram,
// one read a cycle, and then walks the unaligned words beside the phrase.
// reset clears point count, aligned-target mask and sequencer; no clearing pass.
// the result sits in an output register; a stalled result only holds the
// sequencer when the next query is ready to be written out.

module phrase_alignment_span_check
	import pasc_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_WORDS  = MAX_WORDS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_word,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_word
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int MW = $clog2(MAX_WORDS);

	ctrl_t      ctrl;
	seq_flags_t flags;

	// stored sentence state
	logic [CW-1:0]        count_q;
	logic [MAX_WORDS-1:0] mask_q;

	// latched query
	logic [POS_W-1:0] span_lo_q;
	logic [POS_W-1:0] span_hi_q;
	logic [LEN_W-1:0] len_q;

	// scan state
	logic [CW-1:0]      rd_idx_q;
	logic               rd_vld_s1;
	logic [POINT_W-1:0] rd_data;
	logic [LEN_W-1:0]   t_start_q;
	logic [POS_W-1:0]   t_end_q;
	logic               ok_q;

	// walk state
	logic [LEN_W-1:0] pre_t_q;
	logic [LEN_W-1:0] post_t_q;
	logic [POS_W-1:0] pre_q;
	logic [POS_W-1:0] post_q;

	logic out_valid_q;

	// add path
	logic          in_acc;
	logic          add_acc;
	logic          query_acc;
	logic [CW-1:0] eff_cnt;
	logic          do_store;
	logic          tgt_in_mask;

	// scan path
	logic             scan_op;
	logic             scan_issue;
	logic [POS_W-1:0] pt_src;
	logic [POS_W-1:0] pt_tgt;
	logic             in_span;

	// walk path
	logic [LEN_W-1:0] walk_addr;
	logic             walk_aligned;

	// microprogram sequencer
	pasc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// input handshake and add decode
	assign in_ready    = (ctrl.op == OP_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign add_acc     = in_acc && (in_word.func == FUNC_ADD);
	assign query_acc   = in_acc && (in_word.func == FUNC_QUERY);
	assign eff_cnt     = in_word.first_point ? '0 : count_q;
	assign do_store    = add_acc && (eff_cnt < CW'(MAX_POINTS));
	assign tgt_in_mask = ({1'b0, in_word.tgt_pos} < LEN_W'(MAX_WORDS));

	// point read for both scans
	assign scan_op    = (ctrl.op == OP_BSCAN) || (ctrl.op == OP_CSCAN);
	assign scan_issue = scan_op && (rd_idx_q < count_q);

	pasc_ram #(
		.WIDTH (POINT_W),
		.DEPTH (MAX_POINTS)
	) u_points (
		.clk   (clk),
		.we    (do_store),
		.waddr (eff_cnt[AW-1:0]),
		.wdata ({in_word.src_pos, in_word.tgt_pos}),
		.re    (scan_issue),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	assign pt_src  = rd_data[POINT_W-1:POS_W];
	assign pt_tgt  = rd_data[POS_W-1:0];
	assign in_span = (pt_src >= span_lo_q) && (pt_src <= span_hi_q);

	// mask lookup shared by both walks; past the mask reads as aligned
	assign walk_addr = (ctrl.op == OP_PRE) ? (pre_t_q - LEN_W'(1)) : post_t_q;
	always_comb begin
		if (walk_addr >= LEN_W'(MAX_WORDS)) begin
			walk_aligned = 1'b1;
		end else begin
			walk_aligned = mask_q[walk_addr[MW-1:0]];
		end
	end

	// status for the sequencer
	always_comb begin
		flags.no_query  = !(in_valid && (in_word.func == FUNC_QUERY));
		flags.scan_busy = (rd_idx_q < count_q) || rd_vld_s1;
		flags.no_target = (t_start_q == len_q);
		flags.fail      = !ok_q;
		flags.pre_more  = (pre_t_q != '0) && !walk_aligned;
		flags.post_more = (post_t_q < len_q) && !walk_aligned;
		flags.out_busy  = out_valid_q && !out_ready;
	end

	// point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (add_acc) begin
			count_q <= do_store ? eff_cnt + CW'(1) : eff_cnt;
		end
	end

	// aligned-target mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (add_acc) begin
			for (int i = 0; i < MAX_WORDS; i++) begin
				if (do_store && tgt_in_mask && (in_word.tgt_pos[MW-1:0] == MW'(i))) begin
					mask_q[i] <= 1'b1;
				end else if (in_word.first_point) begin
					mask_q[i] <= 1'b0;
				end
			end
		end
	end

	// query latch
	always_ff @(posedge clk) begin
		if (query_acc) begin
			span_lo_q <= in_word.span_start;
			span_hi_q <= in_word.span_end;
			len_q     <= in_word.tgt_length;
		end
	end

	// read index and read-valid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			if (query_acc || (ctrl.op == OP_BEND)) begin
				rd_idx_q <= '0;
			end else if (scan_issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
		end
	end

	// boundary and consistency scans
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
		end else if (query_acc) begin
			ok_q <= 1'b1;
		end else if (ctrl.op == OP_BEND) begin
			ok_q <= (t_start_q != len_q);
		end else if ((ctrl.op == OP_CSCAN) && rd_vld_s1) begin
			if (({1'b0, pt_tgt} >= t_start_q) && (pt_tgt <= t_end_q) && !in_span) begin
				ok_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			t_start_q <= in_word.tgt_length;
			t_end_q   <= '0;
		end else if ((ctrl.op == OP_BSCAN) && rd_vld_s1 && in_span) begin
			if ({1'b0, pt_tgt} < t_start_q) begin
				t_start_q <= {1'b0, pt_tgt};
			end
			if (pt_tgt > t_end_q) begin
				t_end_q <= pt_tgt;
			end
		end
	end

	// unaligned neighbor walks
	always_ff @(posedge clk) begin
		if (query_acc) begin
			pre_q  <= '0;
			post_q <= '0;
		end else begin
			if (ctrl.op == OP_WINIT) begin
				pre_t_q  <= t_start_q;
				post_t_q <= {1'b0, t_end_q} + LEN_W'(1);
			end
			if ((ctrl.op == OP_PRE) && flags.pre_more) begin
				pre_q   <= pre_q + POS_W'(1);
				pre_t_q <= pre_t_q - LEN_W'(1);
			end
			if ((ctrl.op == OP_POST) && flags.post_more) begin
				post_q   <= post_q + POS_W'(1);
				post_t_q <= post_t_q + LEN_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.op == OP_OUT) && !flags.out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctrl.op == OP_OUT) && !flags.out_busy) begin
			out_word.consistent       <= ok_q;
			out_word.phrase_tgt_start <= t_start_q;
			out_word.phrase_tgt_end   <= t_end_q;
			out_word.nulls_before     <= pre_q;
			out_word.nulls_after      <= post_q;
		end
	end

	assign out_valid = out_valid_q;

	// no point read is in flight while new words are taken
	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !rd_vld_s1)
		else $error("point read in flight while idle");

	// point count never passes the store size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("point count beyond store size");

	// a failed query reports no unaligned neighbors
	a_fail_no_nulls: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.consistent) |->
			(out_word.nulls_before == '0) && (out_word.nulls_after == '0))
		else $error("failed query with nonzero null counts");

	// a consistent phrase has an ordered target range
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.consistent) |->
			(out_word.phrase_tgt_start <= {1'b0, out_word.phrase_tgt_end}))
		else $error("consistent phrase with inverted target range");

endmodule

`default_nettype wire
